[design/fsgs_pkg.sv]
`default_nettype none

package fsgs_pkg;

  // Grid dimensions. One stored word holds a full row of cells.
  localparam int unsigned MaxColumns = 64;
  localparam int unsigned MaxRows    = 64;
  localparam int unsigned RowAddrW   = $clog2(MaxRows);
  localparam int unsigned ColIdxW    = $clog2(MaxColumns);
  localparam int unsigned CfgW       = 7;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PLACE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Random pick codes that request a diagonal slide.
  localparam logic [2:0] PICK_LEFT  = 3'd1;
  localparam logic [2:0] PICK_RIGHT = 3'd2;

  // Configuration register indexes.
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_LOAD,
    S_TICK_B,
    S_TICK_RUN,
    S_TICK_LAST,
    S_PLACE_RD,
    S_PLACE_WR,
    S_EMIT
  } state_t;

  typedef logic [MaxColumns-1:0] row_t;

  // Updated contents of a row and of the row beneath it after one tick step.
  typedef struct packed {
    row_t above;
    row_t below;
  } row_pair_t;

  // Applies gravity to every cell of the row above that lies within the column
  // mask, scanning from the highest column down. Straight falls and right slides
  // are independent per column. Left slides chain from column to column, like a
  // carry, so they are resolved with a single wide addition over the bit-reversed row.
  function automatic row_pair_t row_tick(input row_t above, input row_t below,
                                         input row_t mask, input logic [2:0] pick);
    row_t            a_m;
    row_t            prop;
    row_t            gen;
    row_t            x_rev;
    row_t            y_rev;
    logic [MaxColumns:0] sum;
    logic [MaxColumns:0] carry;
    row_t            slide;
    row_t            down;
    row_t            right;
    row_pair_t       res;
    a_m = above & mask;
    // A left slide from column c needs column c-1 below to be free.
    prop = a_m & ~(below << 1);
    prop[0] = 1'b0;
    gen = prop & below;
    for (int j = 0; j < MaxColumns; j++) begin
      x_rev[j] = prop[MaxColumns-1-j];
      y_rev[j] = gen[MaxColumns-1-j];
    end
    sum   = {1'b0, x_rev} + {1'b0, y_rev};
    carry = sum ^ {1'b0, x_rev} ^ {1'b0, y_rev};
    for (int c = 0; c < MaxColumns; c++) begin
      slide[c] = carry[MaxColumns-c];
    end
    res = '0;
    case (pick)
      PICK_LEFT: begin
        down      = a_m & ~below & ~(slide >> 1);
        res.below = below | down | (slide >> 1);
        res.above = above & ~(down | slide);
      end
      PICK_RIGHT: begin
        down      = a_m & ~below;
        right     = a_m & below & ~((below | a_m) >> 1) & (mask >> 1);
        res.below = below | down | (right << 1);
        res.above = above & ~(down | right);
      end
      default: begin
        down      = a_m & ~below;
        res.below = below | down;
        res.above = above & ~down;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[design/falling_sand_grid_step.sv]
// Falling sand grid: an occupancy grid of sand cells, one word per row.
// Input channel (in_valid / in_stall): each item places a grain, clears the
// grid or applies one tick of gravity; codes without meaning change nothing.
// Output channel (out_valid / out_stall): after every item the rows in use are
// sent top row first, one transfer per row, with out_last_row on the final one.
// Configuration channel (cfg_valid / cfg_ready): index 0 sets the columns in
// use, index 1 the rows in use; the user must see that it is written only
// while the block is idle, as the block itself does not enforce this. A tick
// walks the grid row by row through the row memory, one read-modify-write per
// cycle; with a single row in use it changes nothing. A place in range reads
// and then writes its row, and a clear only resets the per-row valid flags.
// The rows then stream out at one per cycle while the receiver does not stall,
// from the same memory, as the tick walk and the row stream share the single
// read port of the row memory. One item is handled at a time; the next is
// taken once the last row is in the output register and leaving.
// Reset empties the grid at once through per-row valid flags (no clearing
// pass) and restores 8 columns and 6 rows. When the receiver stalls, the
// current row is held and the memory is not read until it has been taken.
`default_nettype none

module falling_sand_grid_step
  import fsgs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_operation,
  input  wire logic [5:0]          in_place_column,
  input  wire logic [5:0]          in_place_row,
  input  wire logic [2:0]          in_random_pick,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [5:0]               out_row_index,
  output logic [MaxColumns-1:0]    out_row_bits,
  output logic                     out_last_row,
  // Configuration channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [CfgW-1:0]     cfg_data
);

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [5:0]          pc_r;
  logic [5:0]          pr_r;
  logic [2:0]          pick_r;
  logic [RowAddrW-1:0] row_r, row_nxt;
  logic [RowAddrW-1:0] emit_r, emit_nxt;
  row_t                b_r, b_nxt;
  logic [MaxRows-1:0]  valid_r, valid_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [5:0]          out_index_r, out_index_nxt;
  logic                out_last_r, out_last_nxt;
  logic [CfgW-1:0]     cols_r;
  logic [CfgW-1:0]     rows_r;

  logic [CfgW-1:0]     eff_cols;
  logic [CfgW-1:0]     eff_rows;
  logic [CfgW-1:0]     rows_m1;
  logic [RowAddrW-1:0] last_idx;
  row_t                col_mask;
  row_t                q_eff;
  row_t                ram_rdata;
  logic                ram_we;
  logic [RowAddrW-1:0] ram_waddr;
  row_t                ram_wdata;
  logic                ram_re;
  logic [RowAddrW-1:0] ram_raddr;
  logic                out_free;
  logic                in_accept;
  row_pair_t           pair;

  // Row memory.
  fsgs_ram #(
    .Width (MaxColumns),
    .Depth (MaxRows)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective grid size: zero acts as one, large values saturate.
  always_comb begin
    if (cols_r == '0) begin
      eff_cols = CfgW'(1);
    end else if (cols_r > CfgW'(MaxColumns)) begin
      eff_cols = CfgW'(MaxColumns);
    end else begin
      eff_cols = cols_r;
    end
    if (rows_r == '0) begin
      eff_rows = CfgW'(1);
    end else if (rows_r > CfgW'(MaxRows)) begin
      eff_rows = CfgW'(MaxRows);
    end else begin
      eff_rows = rows_r;
    end
  end

  assign rows_m1  = eff_rows - CfgW'(1);
  assign last_idx = rows_m1[RowAddrW-1:0];

  always_comb begin
    if (eff_cols >= CfgW'(MaxColumns)) begin
      col_mask = '1;
    end else begin
      col_mask = (row_t'(1) << eff_cols[ColIdxW-1:0]) - row_t'(1);
    end
  end

  // A row never written since reset or clear reads as empty.
  assign q_eff = rd_valid_r ? ram_rdata : '0;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign pair = row_tick(q_eff, b_r, col_mask, pick_r);

  // Sequencer: next state, memory accesses and output register loads.
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    emit_nxt      = emit_r;
    b_nxt         = b_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          emit_nxt = '0;
          case (in_operation)
            OP_TICK: begin
              state_nxt = (rows_m1 == '0) ? S_EMIT : S_TICK_LOAD;
            end
            OP_PLACE: begin
              if (({1'b0, in_place_column} < eff_cols) &&
                  ({1'b0, in_place_row} < eff_rows)) begin
                state_nxt = S_PLACE_RD;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            OP_CLEAR: begin
              valid_nxt = '0;
              state_nxt = S_EMIT;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_TICK_LOAD: begin
        // Fetch the bottom row; it only ever receives grains.
        ram_re    = 1'b1;
        ram_raddr = last_idx;
        row_nxt   = last_idx - RowAddrW'(1);
        state_nxt = S_TICK_B;
      end
      S_TICK_B: begin
        b_nxt     = q_eff;
        ram_re    = 1'b1;
        ram_raddr = row_r;
        state_nxt = S_TICK_RUN;
      end
      S_TICK_RUN: begin
        // Settle the row beneath, keep the updated row as the next one beneath.
        ram_we    = 1'b1;
        ram_waddr = row_r + RowAddrW'(1);
        ram_wdata = pair.below;
        b_nxt     = pair.above;
        if (row_r == '0) begin
          state_nxt = S_TICK_LAST;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = row_r - RowAddrW'(1);
          row_nxt   = row_r - RowAddrW'(1);
        end
      end
      S_TICK_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = b_r;
        state_nxt = S_EMIT;
      end
      S_PLACE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pr_r;
        state_nxt = S_PLACE_WR;
      end
      S_PLACE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pr_r;
        ram_wdata = q_eff | (row_t'(1) << pc_r);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // The memory's read register doubles as the output data register.
        if (out_free) begin
          ram_re        = 1'b1;
          ram_raddr     = emit_r;
          out_valid_nxt = 1'b1;
          out_index_nxt = emit_r;
          out_last_nxt  = (emit_r == last_idx);
          if (emit_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt = emit_r + RowAddrW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (ram_we) begin
      valid_nxt[ram_waddr] = 1'b1;
    end
  end

  assign rd_valid_nxt = ram_re ? valid_r[ram_raddr] : rd_valid_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= CfgW'(8);
      rows_r      <= CfgW'(6);
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLUMNS: cols_r <= cfg_data;
          CFG_ROWS:    rows_r <= cfg_data;
          default:     cols_r <= cols_r;
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= op_t'(in_operation);
      pc_r   <= in_place_column;
      pr_r   <= in_place_row;
      pick_r <= in_random_pick;
    end
    row_r       <= row_nxt;
    emit_r      <= emit_nxt;
    b_r         <= b_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_index_r;
  assign out_row_bits  = q_eff & col_mask;
  assign out_last_row  = out_last_r;

  // The memory is never read and written at the same row in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("row memory read and write collide");

  // The final row of an item is the last row in use.
  a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_row) |-> (out_row_index == last_idx))
    else $error("last row flag on wrong row");

  // A held result keeps its row data in the memory's read register.
  a_held_row_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(q_eff))
    else $error("stalled row data changed");

  // A place item that reads its row always goes on to the write of that row.
  a_place_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE_RD) |=> (state_r == S_PLACE_WR) && (op_r == OP_PLACE))
    else $error("place sequence broken");

endmodule

`default_nettype wire

[design/fsgs_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data
// that holds its value while no read is requested.
module fsgs_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
